// ===== src/nbm_pkg.sv =====
// Shared types and constants for the degree-4 NTT base multiplier.
`default_nettype none

package nbm_pkg;

  localparam int unsigned CoefW = 16;

  // Modulus and its inverse mod 2^16 (-767 as a 16-bit pattern).
  localparam int Modulus = 769;
  localparam logic signed [31:0] ModulusW = 32'sd769;
  localparam logic [CoefW-1:0] QInv16 = 16'hFD01;

  // Montgomery factor for the final conversion.
  localparam logic signed [CoefW-1:0] ConvFactor = 16'sd19;

  typedef logic signed [CoefW-1:0] coef_t;

  typedef struct packed {
    coef_t a_coef0;
    coef_t a_coef1;
    coef_t a_coef2;
    coef_t a_coef3;
    coef_t b_coef0;
    coef_t b_coef1;
    coef_t b_coef2;
    coef_t b_coef3;
    coef_t twiddle;
  } in_word_t;

  typedef struct packed {
    coef_t prod_coef0;
    coef_t prod_coef1;
    coef_t prod_coef2;
    coef_t prod_coef3;
  } out_word_t;

  // Load enables of the three Montgomery stages.
  typedef struct packed {
    logic s1;  // product
    logic s2;  // u = low16(p * qinv)
    logic s3;  // p - u * q
  } mont_en_t;

endpackage

`default_nettype wire

// ===== src/nbm_mont.sv =====
// Three-stage Montgomery multiplier array, one lane per operand pair.
`default_nettype none

module nbm_mont #(
  parameter int unsigned Lanes = 1
) (
  input  logic              clk_i,
  input  nbm_pkg::mont_en_t en_i,
  input  nbm_pkg::coef_t    x_i [Lanes],
  input  nbm_pkg::coef_t    y_i [Lanes],
  output nbm_pkg::coef_t    r_o [Lanes]
);
  import nbm_pkg::*;

  logic signed [31:0] p_d  [Lanes];
  logic signed [31:0] p1_q [Lanes];
  logic signed [31:0] p2_q [Lanes];
  logic        [15:0] ul_w [Lanes];
  coef_t              u_d  [Lanes];
  coef_t              u2_q [Lanes];
  logic signed [31:0] d_d  [Lanes];
  logic signed [31:0] d3_q [Lanes];

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      p_d[i]  = 32'(x_i[i]) * 32'(y_i[i]);
      ul_w[i] = p1_q[i][15:0] * QInv16;
      u_d[i]  = ul_w[i];
      // low half of d is zero, so the shift is exact
      d_d[i]  = p2_q[i] - (32'(u2_q[i]) * ModulusW);
      r_o[i]  = d3_q[i][31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Lanes; i++) begin
      if (en_i.s1) begin
        p1_q[i] <= p_d[i];
      end
      if (en_i.s2) begin
        p2_q[i] <= p1_q[i];
        u2_q[i] <= u_d[i];
      end
      if (en_i.s3) begin
        d3_q[i] <= d_d[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ntt_base_multiply_mod769_top.sv =====
// Top level of the degree-4 NTT base multiplier modulo x^4 - zeta, q = 769.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+-----------------------------------
//  in      | in  | in_valid_i / in_ready_o  | in_data_i: a0..a3, b0..b3, twiddle
//  out     | out | out_valid_o / out_ready_i| out_data_o: prod_coef0..3
//  cfg     | in  | cfg_valid_i / cfg_ready_o| cfg_data_i: output_reduce
//
// One word per cycle sustained while out_ready_i is high. The pipe is 12
// register stages: three chained Montgomery multiplies of three stages each,
// plus the combine, sum and output stages.
// Reset clears the stage valid bits and output_reduce; payload regs are not reset.
// Each stage has its own ready, so a stall at the output backs up stage by
// stage and bubbles are squeezed out; in_ready_o drops only when all 12 are full
// and out_ready_i is low.
// cfg is always ready; write it only while the pipeline is empty.
`default_nettype none

module ntt_base_multiply_mod769_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nbm_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nbm_pkg::out_word_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import nbm_pkg::*;

  // Stage map
  localparam int unsigned StMul1    = 0;   // c_i and cross products, 3 stages
  localparam int unsigned StComb    = 3;   // Karatsuba combine
  localparam int unsigned StMul2    = 4;   // multiply by zeta, 3 stages
  localparam int unsigned StSum     = 7;   // raw results
  localparam int unsigned StMul3    = 8;   // factor-19 conversion, 3 stages
  localparam int unsigned StOut     = 11;  // output register
  localparam int unsigned NumStages = 12;

  // Lanes of the first multiplier array
  localparam int unsigned LC0  = 0;
  localparam int unsigned LC1  = 1;
  localparam int unsigned LC2  = 2;
  localparam int unsigned LC3  = 3;
  localparam int unsigned LM13 = 4;
  localparam int unsigned LM23 = 5;
  localparam int unsigned LM01 = 6;
  localparam int unsigned LM02 = 7;
  localparam int unsigned LM03 = 8;
  localparam int unsigned LM12 = 9;
  localparam int unsigned Lanes1 = 10;

  typedef struct packed {
    coef_t c0;
    coef_t e1;
    coef_t e2;
    coef_t r3;
  } carry_t;

  function automatic coef_t fold_neg(coef_t v);
    return v[CoefW-1] ? coef_t'(v + coef_t'(Modulus)) : v;
  endfunction

  // ---------------- handshake / valid chain ----------------
  logic [NumStages-1:0] v_q, v_d, rdy;

  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d[0] = rdy[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NumStages; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[StOut];

  // ---------------- config ----------------
  logic reduce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reduce_q <= 1'b0;
    end else if (cfg_valid_i) begin
      reduce_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // ---------------- stages 0..2: first Montgomery array ----------------
  coef_t as_w [Lanes1];
  coef_t bs_w [Lanes1];
  coef_t m_w  [Lanes1];

  always_comb begin
    as_w[LC0]  = in_data_i.a_coef0;
    as_w[LC1]  = in_data_i.a_coef1;
    as_w[LC2]  = in_data_i.a_coef2;
    as_w[LC3]  = in_data_i.a_coef3;
    as_w[LM13] = in_data_i.a_coef1 + in_data_i.a_coef3;
    as_w[LM23] = in_data_i.a_coef2 + in_data_i.a_coef3;
    as_w[LM01] = in_data_i.a_coef0 + in_data_i.a_coef1;
    as_w[LM02] = in_data_i.a_coef0 + in_data_i.a_coef2;
    as_w[LM03] = in_data_i.a_coef0 + in_data_i.a_coef3;
    as_w[LM12] = in_data_i.a_coef1 + in_data_i.a_coef2;
    bs_w[LC0]  = in_data_i.b_coef0;
    bs_w[LC1]  = in_data_i.b_coef1;
    bs_w[LC2]  = in_data_i.b_coef2;
    bs_w[LC3]  = in_data_i.b_coef3;
    bs_w[LM13] = in_data_i.b_coef1 + in_data_i.b_coef3;
    bs_w[LM23] = in_data_i.b_coef2 + in_data_i.b_coef3;
    bs_w[LM01] = in_data_i.b_coef0 + in_data_i.b_coef1;
    bs_w[LM02] = in_data_i.b_coef0 + in_data_i.b_coef2;
    bs_w[LM03] = in_data_i.b_coef0 + in_data_i.b_coef3;
    bs_w[LM12] = in_data_i.b_coef1 + in_data_i.b_coef2;
  end

  nbm_mont #(.Lanes(Lanes1)) u_mont1 (
    .clk_i (clk_i),
    .en_i  ('{s1: rdy[StMul1], s2: rdy[StMul1+1], s3: rdy[StMul1+2]}),
    .x_i   (as_w),
    .y_i   (bs_w),
    .r_o   (m_w)
  );

  // twiddle rides along until the zeta multiply
  coef_t z_q [StComb+1];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      z_q[0] <= in_data_i.twiddle;
    end
    for (int k = 1; k <= StComb; k++) begin
      if (rdy[k]) begin
        z_q[k] <= z_q[k-1];
      end
    end
  end

  // ---------------- stage 3: combine ----------------
  coef_t  t0_q, t1_q, c3_q;
  carry_t cr_q [StSum-StComb];

  always_ff @(posedge clk_i) begin
    if (rdy[StComb]) begin
      t0_q     <= m_w[LM13] - m_w[LC1] - m_w[LC3] + m_w[LC2];
      t1_q     <= m_w[LM23] - m_w[LC2] - m_w[LC3];
      c3_q     <= m_w[LC3];
      cr_q[0]  <= '{c0: m_w[LC0],
                    e1: m_w[LM01] - m_w[LC0] - m_w[LC1],
                    e2: m_w[LC1] + m_w[LM02] - m_w[LC0] - m_w[LC2],
                    r3: m_w[LM03] - m_w[LC0] - m_w[LC3] + m_w[LM12]
                        - m_w[LC1] - m_w[LC2]};
    end
    for (int k = 1; k < StSum - StComb; k++) begin
      if (rdy[StComb+k]) begin
        cr_q[k] <= cr_q[k-1];
      end
    end
  end

  // ---------------- stages 4..6: multiply by zeta ----------------
  coef_t zx_w [3];
  coef_t zy_w [3];
  coef_t mz_w [3];

  always_comb begin
    zx_w[0] = t0_q;
    zx_w[1] = t1_q;
    zx_w[2] = c3_q;
    for (int i = 0; i < 3; i++) begin
      zy_w[i] = z_q[StComb];
    end
  end

  nbm_mont #(.Lanes(3)) u_mont2 (
    .clk_i (clk_i),
    .en_i  ('{s1: rdy[StMul2], s2: rdy[StMul2+1], s3: rdy[StMul2+2]}),
    .x_i   (zx_w),
    .y_i   (zy_w),
    .r_o   (mz_w)
  );

  // ---------------- stage 7: raw results, carried to the output ----------------
  out_word_t rw_q [StOut-StSum];
  carry_t    cr_last;

  assign cr_last = cr_q[StSum-StComb-1];

  always_ff @(posedge clk_i) begin
    if (rdy[StSum]) begin
      rw_q[0] <= '{prod_coef0: mz_w[0] + cr_last.c0,
                   prod_coef1: mz_w[1] + cr_last.e1,
                   prod_coef2: mz_w[2] + cr_last.e2,
                   prod_coef3: cr_last.r3};
    end
    for (int k = 1; k < StOut - StSum; k++) begin
      if (rdy[StSum+k]) begin
        rw_q[k] <= rw_q[k-1];
      end
    end
  end

  // ---------------- stages 8..10: factor-19 conversion ----------------
  coef_t fx_w [4];
  coef_t fy_w [4];
  coef_t mf_w [4];

  always_comb begin
    fx_w[0] = rw_q[0].prod_coef0;
    fx_w[1] = rw_q[0].prod_coef1;
    fx_w[2] = rw_q[0].prod_coef2;
    fx_w[3] = rw_q[0].prod_coef3;
    for (int i = 0; i < 4; i++) begin
      fy_w[i] = ConvFactor;
    end
  end

  nbm_mont #(.Lanes(4)) u_mont3 (
    .clk_i (clk_i),
    .en_i  ('{s1: rdy[StMul3], s2: rdy[StMul3+1], s3: rdy[StMul3+2]}),
    .x_i   (fx_w),
    .y_i   (fy_w),
    .r_o   (mf_w)
  );

  // ---------------- stage 11: output register ----------------
  out_word_t out_d, out_q, raw_last;

  assign raw_last = rw_q[StOut-StSum-1];

  always_comb begin
    if (reduce_q) begin
      out_d = '{prod_coef0: fold_neg(mf_w[0]),
                prod_coef1: fold_neg(mf_w[1]),
                prod_coef2: fold_neg(mf_w[2]),
                prod_coef3: fold_neg(mf_w[3])};
    end else begin
      out_d = raw_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StOut]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // ---------------- assertions ----------------
  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[StMul1])
    else $error("accepted word did not enter the first stage");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((&v_q) && !out_ready_i))
    else $error("input blocked while a stage is free");

  a_comb_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[StComb] && !rdy[StComb+1] |=> v_q[StComb] && $stable(t0_q) && $stable(t1_q))
    else $error("combine stage lost or changed a stalled word");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> reduce_q == $past(cfg_data_i))
    else $error("config write not taken");

endmodule

`default_nettype wire
